@@ design/pfde_pkg.sv @@
// shared types, constants and helpers of the playfair digraph encryptor
`default_nettype none

package pfde_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE     = 5;
    localparam int POS_W    = 3;
    localparam int CELLS    = SIDE * SIDE;
    localparam int CELLS_W  = 60;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
    localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_LAST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD       = 3'd4;

    typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                last;
    } pair_t;

    function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] c);
        fold = (c == CODE_J) ? CODE_I : c;
    endfunction

endpackage

`default_nettype wire

@@ design/pfde_pair.sv @@
// digraph former: holds a first letter, splits doubles, pads a lone last letter
`default_nettype none

module pfde_pair (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [pfde_pkg::LETTER_W-1:0] s_letter,
    input  wire logic                         s_last,
    input  wire logic [pfde_pkg::LETTER_W-1:0] filler_letter,
    input  wire logic [pfde_pkg::LETTER_W-1:0] pad_letter,
    input  wire logic                         pair_take,
    output logic                              pair_valid,
    output pfde_pkg::pair_t                   pair
);

    logic                          held_valid_reg, held_valid_next;
    logic [pfde_pkg::LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                          ext_valid_reg, ext_valid_next;
    logic [pfde_pkg::LETTER_W-1:0] ext_letter_reg, ext_letter_next;
    logic                          pair_valid_reg, pair_valid_next;
    pfde_pkg::pair_t               pair_reg, pair_next;
    logic                          slot_free;
    logic                          accept;
    logic [pfde_pkg::LETTER_W-1:0] lt;

    assign slot_free  = !pair_valid_reg || pair_take;
    assign s_ready    = slot_free && !ext_valid_reg;
    assign accept     = s_valid && s_ready;
    assign lt         = pfde_pkg::fold(s_letter);
    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

    always_comb begin
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        ext_valid_next   = ext_valid_reg;
        ext_letter_next  = ext_letter_reg;
        pair_valid_next  = pair_valid_reg && !pair_take;
        pair_next        = pair_reg;
        if (slot_free && ext_valid_reg) begin
            // pad pair after a doubled final letter
            pair_valid_next = 1'b1;
            pair_next       = '{first: ext_letter_reg,
                                second: pfde_pkg::fold(pad_letter), last: 1'b1};
            ext_valid_next  = 1'b0;
        end
        if (accept) begin
            if (!held_valid_reg) begin
                if (s_last) begin
                    pair_valid_next = 1'b1;
                    pair_next       = '{first: lt,
                                        second: pfde_pkg::fold(pad_letter), last: 1'b1};
                end else begin
                    held_valid_next  = 1'b1;
                    held_letter_next = lt;
                end
            end else if (held_letter_reg != lt) begin
                pair_valid_next = 1'b1;
                pair_next       = '{first: held_letter_reg, second: lt, last: s_last};
                held_valid_next = 1'b0;
            end else begin
                pair_valid_next = 1'b1;
                pair_next       = '{first: held_letter_reg,
                                    second: pfde_pkg::fold(filler_letter), last: 1'b0};
                if (s_last) begin
                    held_valid_next = 1'b0;
                    ext_valid_next  = 1'b1;
                    ext_letter_next = lt;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            ext_valid_reg  <= 1'b0;
            pair_valid_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            ext_valid_reg  <= ext_valid_next;
            pair_valid_reg <= pair_valid_next;
        end
        held_letter_reg <= held_letter_next;
        ext_letter_reg  <= ext_letter_next;
        pair_reg        <= pair_next;
    end

endmodule

`default_nettype wire

@@ design/pfde_cipher.sv @@
// key square lookup and playfair substitution of one digraph
`default_nettype none

module pfde_cipher (
    input  wire pfde_pkg::square_t             square,
    input  wire pfde_pkg::pair_t               pair,
    output logic [pfde_pkg::LETTER_W-1:0]      cipher_first,
    output logic [pfde_pkg::LETTER_W-1:0]      cipher_second
);

    logic [pfde_pkg::POS_W-1:0] ra, ca, rb, cb;
    logic [pfde_pkg::POS_W-1:0] xr, xc, yr, yc;
    logic                       fa, fb;

    function automatic logic [pfde_pkg::POS_W-1:0] step(input logic [pfde_pkg::POS_W-1:0] p);
        step = (p == pfde_pkg::POS_W'(pfde_pkg::SIDE - 1)) ? '0 : p + 1'b1;
    endfunction

    // first matching cell wins, no match sits at row 0 column 0
    always_comb begin
        ra = '0;
        ca = '0;
        rb = '0;
        cb = '0;
        fa = 1'b0;
        fb = 1'b0;
        for (int r = 0; r < pfde_pkg::SIDE; r++) begin
            for (int c = 0; c < pfde_pkg::SIDE; c++) begin
                if (!fa && square[r][c] == pair.first) begin
                    fa = 1'b1;
                    ra = pfde_pkg::POS_W'(r);
                    ca = pfde_pkg::POS_W'(c);
                end
                if (!fb && square[r][c] == pair.second) begin
                    fb = 1'b1;
                    rb = pfde_pkg::POS_W'(r);
                    cb = pfde_pkg::POS_W'(c);
                end
            end
        end
    end

    always_comb begin
        if (ra == rb) begin
            xr = ra;
            xc = step(ca);
            yr = rb;
            yc = step(cb);
        end else if (ca == cb) begin
            xr = step(ra);
            xc = ca;
            yr = step(rb);
            yc = cb;
        end else begin
            xr = ra;
            xc = cb;
            yr = rb;
            yc = ca;
        end
    end

    assign cipher_first  = square[xr][xc];
    assign cipher_second = square[yr][yc];

endmodule

`default_nettype wire

@@ design/playfair_digraph_encrypt.sv @@
// top level of the playfair digraph encryptor
//
//  port group  dir  beat contents
//  s_*         in   s_tdata: letter[4:0]; s_tlast: end of text
//  m_*         out  m_tdata: cipher_first[4:0], cipher_second[9:5]; m_tlast: final pair
//  cfg_*       in   cfg_index selects register, cfg_data holds its value
//
//  one letter per cycle while s_tready is high; letters pass the pair and output registers
//  a doubled final letter yields two output beats; s_tready is low until its pad pair forms
//  aresetn is synchronous, active low; clears held letter, stages, square; filler X, pad Z
//  m_tready low stalls the output register; s_tready follows through the pair stage
//  cfg_ready is always high
`default_nettype none

module playfair_digraph_encrypt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pfde_pkg::S_TDATA_W-1:0]    s_tdata,   // letter[4:0]
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pfde_pkg::M_TDATA_W-1:0]         m_tdata,   // cipher_first, cipher_second
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfde_pkg::CELLS_W-1:0]      cfg_data
);

    logic [pfde_pkg::CELLS_W-1:0]  cells_low_reg, cells_mid_reg;
    logic [pfde_pkg::LETTER_W-1:0] cell_last_reg, filler_reg, pad_reg;
    pfde_pkg::square_t             square;
    logic                          pair_valid;
    pfde_pkg::pair_t               pair;
    logic                          out_load;
    logic [pfde_pkg::LETTER_W-1:0] c_first, c_second;
    logic                          m_tvalid_reg;
    logic [pfde_pkg::LETTER_W-1:0] first_reg, second_reg;
    logic                          last_reg;

    assign cfg_ready = 1'b1;
    assign square    = pfde_pkg::square_t'({cell_last_reg, cells_mid_reg, cells_low_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_low_reg <= '0;
            cells_mid_reg <= '0;
            cell_last_reg <= '0;
            filler_reg    <= pfde_pkg::CODE_X;
            pad_reg       <= pfde_pkg::CODE_Z;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pfde_pkg::CFG_CELLS_LOW: cells_low_reg <= cfg_data;
                pfde_pkg::CFG_CELLS_MID: cells_mid_reg <= cfg_data;
                pfde_pkg::CFG_CELL_LAST: cell_last_reg <= cfg_data[pfde_pkg::LETTER_W-1:0];
                pfde_pkg::CFG_FILLER:    filler_reg    <= cfg_data[pfde_pkg::LETTER_W-1:0];
                pfde_pkg::CFG_PAD:       pad_reg       <= cfg_data[pfde_pkg::LETTER_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_load = pair_valid && (!m_tvalid_reg || m_tready);

    pfde_pair u_pair (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_letter      (s_tdata[pfde_pkg::LETTER_W-1:0]),
        .s_last        (s_tlast),
        .filler_letter (filler_reg),
        .pad_letter    (pad_reg),
        .pair_take     (out_load),
        .pair_valid    (pair_valid),
        .pair          (pair)
    );

    pfde_cipher u_cipher (
        .square        (square),
        .pair          (pair),
        .cipher_first  (c_first),
        .cipher_second (c_second)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            first_reg  <= c_first;
            second_reg <= c_second;
            last_reg   <= pair.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pfde_pkg::M_TDATA_W - 2 * pfde_pkg::LETTER_W){1'b0}},
                       second_reg, first_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ design/pfde_checker.sv @@
// port checks of the playfair digraph encryptor, bound to the top level
`default_nettype none

module pfde_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [pfde_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    localparam int PAIR_W = 2 * pfde_pkg::LETTER_W;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[pfde_pkg::M_TDATA_W-1:PAIR_W] == '0)
        else $error("nonzero fill bits in output beat");

endmodule

bind playfair_digraph_encrypt pfde_checker u_pfde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
